// File: rtl/dbt_pkg.sv
// dbt_pkg: shared constants, codes and types of the dirty block bitmap tracker.
// No dependencies; used by dbt_wordop, dbt_bitmap and the top level.
`timescale 1ns / 1ps
package dbt_pkg;

  localparam int unsigned NUM_BLOCKS = 65536;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WORD_COUNT = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WADDR_W    = $clog2(WORD_COUNT);
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned BLK_W      = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned SHIFT_MAX  = 20;
  localparam int unsigned BS_W       = SHIFT_MAX + 1;
  localparam int unsigned SH_W       = 5;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned OFF_W      = 40;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned CS_W       = OFF_W + 1;
  localparam int unsigned CL_W       = 48;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned IN_W       = 80;
  localparam int unsigned OUT_W      = 88;

  localparam logic [CL_W-1:0] CL_CAP = {CL_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_BLOCK_SHIFT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_BLOCK_COUNT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_CACHE_DISABLE = 2'd2;

  typedef enum logic [2:0] {
    CMD_RECORD_WRITE = 3'd0,
    CMD_SET_RANGE    = 3'd1,
    CMD_CLEAR_RANGE  = 3'd2,
    CMD_GET_EXTENT   = 3'd3,
    CMD_FLUSH_CACHE  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TRACK_ERR = 2'd2,
    ST_NO_EXTENT = 2'd3
  } status_t;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WADDR_W-1:0]   waddr_t;

  // bit window operation on one bitmap word
  typedef struct packed {
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
    logic             val;
  } wop_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } whit_t;

endpackage

// File: rtl/dirty_block_bitmap_tracker_core.sv
// Dirty block bitmap tracker: one dirty bit per block, sticky error flag and
// a coalescing extent cache. Depends on dbt_pkg, dbt_bitmap, dbt_wordop.
//
// One request at a time. A request is decoded and then works through the 32-bit
// bitmap words one after another: by a cache flush, by a set or clear range,
// by the extent search (words walked from the start block to the end of the
// run) and by the optional clear of the returned run. All word work goes
// through one read-modify-write path on the single bitmap memory. After reset
// the bitmap's 2048 words are zeroed, during which no request is taken;
// configuration writes are taken at any time.
`timescale 1ns / 1ps
module dirty_block_bitmap_tracker_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // command[2:0], byte_offset[42:3], byte_length[74:43], clear_after_read[75]
  input  logic [dbt_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status[1:0], extent_offset[41:2], extent_length[81:42]
  output logic [dbt_pkg::OUT_W-1:0]    m_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dbt_pkg::IDX_W-1:0]    cfg_index,
  input  logic [dbt_pkg::CNT_W-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE, S_PREP, S_EXEC, S_FLUSH, S_MARK, S_SETCLR, S_POST,
    S_SINIT, S_SRD, S_SCAN, S_RRD, S_RUN, S_XDONE, S_WRD, S_WR, S_RESP
  } state_t;

  state_t state;

  logic [dbt_pkg::SH_W-1:0]  blk_shift;
  logic [dbt_pkg::CNT_W-1:0] blk_count;
  logic                      cache_dis;

  dbt_pkg::cmd_t             cmd;
  logic [dbt_pkg::OFF_W-1:0] off;
  logic [dbt_pkg::LEN_W-1:0] len;
  logic                      clr;

  logic [dbt_pkg::OFF_W-1:0]   blk;
  logic [dbt_pkg::OFF_W+1:0]   topw;
  logic [dbt_pkg::OFF_W:0]     topq;
  logic [dbt_pkg::LEN_W:0]     nsc;
  logic [dbt_pkg::OFF_W+1:0]   nw;
  logic                        chain_hit;

  logic                      err;
  logic [dbt_pkg::CS_W-1:0]  cs;
  logic [dbt_pkg::CL_W-1:0]  cl;
  logic [dbt_pkg::CS_W-1:0]  ms;
  logic [dbt_pkg::CL_W-1:0]  mn;
  logic                      flushing;

  logic [dbt_pkg::BLK_W-1:0] opa;
  logic [dbt_pkg::BLK_W-1:0] opb;
  logic [dbt_pkg::BLK_W-1:0] endb;
  logic [dbt_pkg::BLK_W-1:0] eb;
  logic                      rval;
  logic                      ret_post;
  dbt_pkg::waddr_t           rw;

  dbt_pkg::status_t          status;
  logic [dbt_pkg::OFF_W-1:0] xoff;
  logic [dbt_pkg::OFF_W-1:0] xlen;

  // datapath helpers
  logic [dbt_pkg::SH_W-1:0]  sh;
  logic [dbt_pkg::BLK_W-1:0] lim;
  logic [dbt_pkg::BS_W-1:0]  bs_m1;
  logic [dbt_pkg::CL_W:0]    sat_sum;
  logic                      mark_bad;
  logic [dbt_pkg::BLK_W-1:0] mark_last;
  logic                      sc_bad;
  logic [dbt_pkg::BLK_W-1:0] sc_last;
  logic [dbt_pkg::BLK_W-1:0] hit_blk;
  dbt_pkg::waddr_t           opa_word;
  dbt_pkg::waddr_t           opb_word;
  logic                      base_hit;
  logic                      top_hit;

  dbt_pkg::word_t rdata;
  dbt_pkg::word_t wout;
  dbt_pkg::wop_t  wop;
  dbt_pkg::whit_t whit;
  logic           bm_ready;
  logic           bm_we;

  assign sh  = (blk_shift > dbt_pkg::SH_W'(dbt_pkg::SHIFT_MAX)) ?
               dbt_pkg::SH_W'(dbt_pkg::SHIFT_MAX) : blk_shift;
  assign lim = ({1'b0, blk_count} > (dbt_pkg::CNT_W + 1)'(dbt_pkg::NUM_BLOCKS)) ?
               dbt_pkg::BLK_W'(dbt_pkg::NUM_BLOCKS) : dbt_pkg::BLK_W'(blk_count);
  assign bs_m1 = (dbt_pkg::BS_W'(1) << sh) - 1'b1;

  assign sat_sum = (dbt_pkg::CL_W + 1)'(cl) + (dbt_pkg::CL_W + 1)'(nw);

  assign mark_bad  = (ms > dbt_pkg::CS_W'(lim)) ||
                     (mn > dbt_pkg::CL_W'(dbt_pkg::BLK_W'(lim - ms[dbt_pkg::BLK_W-1:0])));
  assign mark_last = dbt_pkg::BLK_W'(ms[dbt_pkg::BLK_W-1:0] + mn[dbt_pkg::BLK_W-1:0] - 1'b1);

  assign sc_bad  = (nsc == '0) || (blk > dbt_pkg::OFF_W'(lim)) ||
                   (nsc > (dbt_pkg::LEN_W + 1)'(dbt_pkg::BLK_W'(lim - blk[dbt_pkg::BLK_W-1:0])));
  assign sc_last = dbt_pkg::BLK_W'(blk[dbt_pkg::BLK_W-1:0] + nsc[dbt_pkg::BLK_W-1:0] - 1'b1);

  assign opa_word = opa[dbt_pkg::BIT_W+dbt_pkg::WADDR_W-1:dbt_pkg::BIT_W];
  assign opb_word = opb[dbt_pkg::BIT_W+dbt_pkg::WADDR_W-1:dbt_pkg::BIT_W];
  assign base_hit = (rw == opa_word);
  assign top_hit  = (rw == opb_word);
  assign hit_blk  = dbt_pkg::BLK_W'({rw, whit.pos});

  assign wop.lo  = base_hit ? opa[dbt_pkg::BIT_W-1:0] : '0;
  assign wop.hi  = top_hit ? opb[dbt_pkg::BIT_W-1:0] : '1;
  assign wop.val = (state == S_WR) ? rval : (state == S_SCAN);

  assign bm_we     = (state == S_WR);
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  dbt_bitmap u_bitmap (
    .clk   (clk),
    .rst   (rst),
    .raddr (rw),
    .rdata (rdata),
    .we    (bm_we),
    .waddr (rw),
    .wdata (wout),
    .ready (bm_ready)
  );

  dbt_wordop u_wordop (
    .data (rdata),
    .op   (wop),
    .wout (wout),
    .hit  (whit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_shift <= dbt_pkg::SH_W'(12);
      blk_count <= dbt_pkg::CNT_W'(65536);
      cache_dis <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dbt_pkg::REG_BLOCK_SHIFT:   blk_shift <= cfg_data[dbt_pkg::SH_W-1:0];
        dbt_pkg::REG_BLOCK_COUNT:   blk_count <= cfg_data;
        dbt_pkg::REG_CACHE_DISABLE: cache_dis <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      m_tvalid <= 1'b0;
      err      <= 1'b0;
      cs       <= '0;
      cl       <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_RESP) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (bm_ready) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= dbt_pkg::cmd_t'(s_tdata[2:0]);
            off   <= s_tdata[42:3];
            len   <= s_tdata[74:43];
            clr   <= s_tdata[75];
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          status <= dbt_pkg::ST_OK;
          xoff   <= '0;
          xlen   <= '0;
          blk    <= off >> sh;
          topw   <= ((dbt_pkg::OFF_W + 2)'(off) + (dbt_pkg::OFF_W + 2)'(len) +
                     (dbt_pkg::OFF_W + 2)'(bs_m1)) >> sh;
          topq   <= ((dbt_pkg::OFF_W + 1)'(off) + (dbt_pkg::OFF_W + 1)'(len)) >> sh;
          nsc    <= ((dbt_pkg::LEN_W + 1)'(len) + (dbt_pkg::LEN_W + 1)'(bs_m1)) >> sh;
          state  <= S_PREP;
        end
        S_PREP: begin
          nw        <= topw - (dbt_pkg::OFF_W + 2)'(blk);
          chain_hit <= ((dbt_pkg::CL_W + 1)'(cs) + (dbt_pkg::CL_W + 1)'(cl)) ==
                       (dbt_pkg::CL_W + 1)'(blk);
          state     <= S_EXEC;
        end
        S_EXEC: begin
          unique case (cmd)
            dbt_pkg::CMD_RECORD_WRITE: begin
              if (err) begin
                status <= dbt_pkg::ST_TRACK_ERR;
                state  <= S_RESP;
              end else if (len == '0) begin
                state <= S_RESP;
              end else if (cache_dis) begin
                ms       <= dbt_pkg::CS_W'(blk);
                mn       <= dbt_pkg::CL_W'(nw);
                flushing <= 1'b0;
                state    <= S_MARK;
              end else if (chain_hit) begin
                cl    <= sat_sum[dbt_pkg::CL_W] ? dbt_pkg::CL_CAP : sat_sum[dbt_pkg::CL_W-1:0];
                state <= S_RESP;
              end else begin
                cs <= dbt_pkg::CS_W'(blk);
                cl <= dbt_pkg::CL_W'(nw);
                if (cl != '0) begin
                  ms       <= cs;
                  mn       <= cl;
                  flushing <= 1'b0;
                  state    <= S_MARK;
                end else begin
                  state <= S_RESP;
                end
              end
            end
            dbt_pkg::CMD_SET_RANGE: begin
              if (err) begin
                status <= dbt_pkg::ST_TRACK_ERR;
                state  <= S_RESP;
              end else begin
                state <= S_SETCLR;
              end
            end
            dbt_pkg::CMD_CLEAR_RANGE: begin
              if (err) begin
                status <= dbt_pkg::ST_TRACK_ERR;
                state  <= S_RESP;
              end else begin
                state <= S_FLUSH;
              end
            end
            dbt_pkg::CMD_GET_EXTENT: begin
              if (blk > dbt_pkg::OFF_W'(lim)) begin
                status <= dbt_pkg::ST_INVALID;
                state  <= S_RESP;
              end else if (err) begin
                status <= dbt_pkg::ST_TRACK_ERR;
                state  <= S_RESP;
              end else begin
                state <= S_FLUSH;
              end
            end
            dbt_pkg::CMD_FLUSH_CACHE: begin
              state <= S_FLUSH;
            end
            default: begin
              state <= S_RESP;
            end
          endcase
        end
        S_FLUSH: begin
          if (cl == '0) begin
            state <= S_POST;
          end else begin
            ms       <= cs;
            mn       <= cl;
            flushing <= 1'b1;
            state    <= S_MARK;
          end
        end
        S_MARK: begin
          if (mark_bad) begin
            err   <= 1'b1;
            state <= S_POST;
          end else begin
            if (flushing) begin
              cs <= dbt_pkg::CS_W'(cs + dbt_pkg::CS_W'(cl));
              cl <= '0;
            end
            opa      <= ms[dbt_pkg::BLK_W-1:0];
            opb      <= mark_last;
            rw       <= ms[dbt_pkg::BIT_W+dbt_pkg::WADDR_W-1:dbt_pkg::BIT_W];
            rval     <= 1'b1;
            ret_post <= 1'b1;
            state    <= S_WRD;
          end
        end
        S_POST: begin
          unique case (cmd)
            dbt_pkg::CMD_CLEAR_RANGE: state <= S_SETCLR;
            dbt_pkg::CMD_GET_EXTENT:  state <= S_SINIT;
            default: begin
              status <= err ? dbt_pkg::ST_TRACK_ERR : dbt_pkg::ST_OK;
              state  <= S_RESP;
            end
          endcase
        end
        S_SETCLR: begin
          if (sc_bad) begin
            status <= dbt_pkg::ST_INVALID;
            state  <= S_RESP;
          end else begin
            opa      <= blk[dbt_pkg::BLK_W-1:0];
            opb      <= sc_last;
            rw       <= blk[dbt_pkg::BIT_W+dbt_pkg::WADDR_W-1:dbt_pkg::BIT_W];
            rval     <= (cmd == dbt_pkg::CMD_SET_RANGE);
            ret_post <= 1'b0;
            state    <= S_WRD;
          end
        end
        S_SINIT: begin
          endb <= (topq > (dbt_pkg::OFF_W + 1)'(lim)) ? lim : topq[dbt_pkg::BLK_W-1:0];
          opa  <= blk[dbt_pkg::BLK_W-1:0];
          opb  <= lim - 1'b1;
          rw   <= blk[dbt_pkg::BIT_W+dbt_pkg::WADDR_W-1:dbt_pkg::BIT_W];
          if (blk[dbt_pkg::BLK_W-1:0] == lim) begin
            status <= dbt_pkg::ST_NO_EXTENT;
            state  <= S_RESP;
          end else begin
            state <= S_SRD;
          end
        end
        S_SRD: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (whit.found) begin
            if (hit_blk > endb) begin
              status <= dbt_pkg::ST_NO_EXTENT;
              state  <= S_RESP;
            end else begin
              opa   <= hit_blk;
              state <= S_RRD;
            end
          end else if (top_hit) begin
            status <= dbt_pkg::ST_NO_EXTENT;
            state  <= S_RESP;
          end else begin
            rw    <= rw + 1'b1;
            state <= S_SRD;
          end
        end
        S_RRD: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (whit.found) begin
            eb    <= hit_blk;
            state <= S_XDONE;
          end else if (top_hit) begin
            eb    <= lim;
            state <= S_XDONE;
          end else begin
            rw    <= rw + 1'b1;
            state <= S_RRD;
          end
        end
        S_XDONE: begin
          xoff <= dbt_pkg::OFF_W'(dbt_pkg::OFF_W'(opa) << sh);
          xlen <= dbt_pkg::OFF_W'(dbt_pkg::OFF_W'(dbt_pkg::BLK_W'(eb - opa)) << sh);
          if (clr) begin
            opb      <= eb - 1'b1;
            rw       <= opa_word;
            rval     <= 1'b0;
            ret_post <= 1'b0;
            state    <= S_WRD;
          end else begin
            state <= S_RESP;
          end
        end
        S_WRD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (top_hit) begin
            state <= ret_post ? S_POST : S_RESP;
          end else begin
            rw    <= rw + 1'b1;
            state <= S_WRD;
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, xlen, xoff, status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_DECODE)
    else $error("accepted request not decoded");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err |=> err)
    else $error("error flag dropped");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    state == S_MARK && flushing && !mark_bad |=> cl == '0)
    else $error("flushed extent still pending");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> rw <= opb_word)
    else $error("range walk past last word");

  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !bm_ready |-> !s_tready)
    else $error("request taken during bitmap clear");

endmodule

// File: rtl/dbt_wordop.sv
// dbt_wordop: shared word unit; writes a bit window to a value and finds the
// first bit in the window equal to that value. Depends on dbt_pkg.
`timescale 1ns / 1ps
module dbt_wordop (
  input  dbt_pkg::word_t data,
  input  dbt_pkg::wop_t  op,
  output dbt_pkg::word_t wout,
  output dbt_pkg::whit_t hit
);

  dbt_pkg::word_t mask;

  always_comb begin
    mask = '0;
    hit  = '0;
    for (int i = dbt_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (dbt_pkg::BIT_W'(i) >= op.lo && dbt_pkg::BIT_W'(i) <= op.hi) begin
        mask[i] = 1'b1;
        if (data[i] == op.val) begin
          hit.found = 1'b1;
          hit.pos   = dbt_pkg::BIT_W'(i);
        end
      end
    end
  end

  assign wout = op.val ? (data | mask) : (data & ~mask);

endmodule

// File: rtl/dbt_bitmap.sv
// dbt_bitmap: dirty bitmap memory, one write and one registered read port,
// with a zeroing sweep after reset. Depends on dbt_pkg.
`timescale 1ns / 1ps
module dbt_bitmap (
  input  logic            clk,
  input  logic            rst,
  input  dbt_pkg::waddr_t raddr,
  output dbt_pkg::word_t  rdata,
  input  logic            we,
  input  dbt_pkg::waddr_t waddr,
  input  dbt_pkg::word_t  wdata,
  output logic            ready
);

  dbt_pkg::word_t  mem [dbt_pkg::WORD_COUNT];
  dbt_pkg::waddr_t clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      ready   <= 1'b0;
    end else if (!ready) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == dbt_pkg::WADDR_W'(dbt_pkg::WORD_COUNT - 1)) begin
        ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      mem[clr_cnt] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
